>>> design/svbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svbm_pkg
// Shared types and constants of the servo bus packet master.
// ----------------------------------------------------------------------------
package svbm_pkg;

    // Input word codes
    localparam logic [1:0] CMD_ISSUE = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Output word kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BUSY = 2'd2;

    // Completion status
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_TIMEOUT     = 2'd2;
    localparam logic [1:0] ST_CHECKSUM    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT   = 1'b0;
    localparam logic CFG_MAX_TRIES = 1'b1;

    // Protocol constants
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [7:0] INSTR_READ   = 8'h02;
    localparam logic [7:0] INSTR_WRITE  = 8'h03;
    localparam logic [2:0] MAX_COUNT    = 3'd4;
    localparam int         LEN_IDX      = 3;   // length byte of a reply
    localparam int         DATA_IDX     = 5;   // first data byte of a reply

    // Reset values and defaults
    localparam logic [7:0] TIMEOUT_RST   = 8'd20;
    localparam logic [3:0] MAX_TRIES_RST = 4'd3;
    localparam int         RX_DEPTH_DEF  = 16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  servo_id;
        logic [7:0]  instruction;
        logic [7:0]  reg_addr;
        logic [2:0]  data_count;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [31:0] read_data;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  instr;
        logic [7:0]  reg_addr;
        logic [2:0]  count;
        logic [31:0] data;
    } held_cmd_t;

    typedef struct packed {
        logic start;   // restart frame at first byte
        logic adv;     // current byte taken
    } tx_ctrl_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } tx_stat_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_BCAST
    } phase_t;

    typedef enum logic [2:0] {
        S_READY,
        S_SEND,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } fsm_t;

endpackage
`default_nettype wire

>>> design/servo_bus_packet_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_bus_packet_master
// Servo bus master: builds command frames, collects reply bytes, checks
// reply checksums, times out and retries.
// ----------------------------------------------------------------------------
//  channel | signals                               | word
//  --------+---------------------------------------+----------------------
//  in      | in_valid, in_ready, in_data           | in_word_t
//  out     | out_valid, out_ready, out_data        | out_word_t
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | 1-bit index, 8 data
//
//  A command that sends a frame emits 7 to 11 byte words, one per cycle
//  while out_ready is high.
//  A reply that completes a read fetches its data bytes from the buffer
//  memory one at a time, through S_RD_ADDR and S_RD_DATA (registered read
//  data), then posts the result from S_DONE.
//  in_ready is low while a frame or data fetch runs or the output register
//  holds a word that is not being taken.
//  Reset clears all control state; the reply buffer is not cleared.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module servo_bus_packet_master
    import svbm_pkg::*;
#(
    parameter int RX_BUFFER_DEPTH = RX_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire in_word_t   in_data,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      out_word_t  out_data,
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int AW = $clog2(RX_BUFFER_DEPTH);
    localparam logic [AW-1:0] CNT_MAX = AW'(RX_BUFFER_DEPTH - 1);

    fsm_t          fsm_reg, fsm_next;
    phase_t        phase_reg, phase_next;
    held_cmd_t     held_reg, held_next;
    logic [AW-1:0] rx_count_reg, rx_count_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    rsum_reg, rsum_next;
    logic [7:0]    elapsed_reg, elapsed_next;
    logic [3:0]    try_reg, try_next;
    logic [1:0]    rd_idx_reg, rd_idx_next;
    logic [31:0]   rdata_reg, rdata_next;
    logic          out_valid_reg, out_valid_next;
    out_word_t     out_word_reg, out_word_next;
    logic [7:0]    timeout_reg;
    logic [3:0]    max_tries_reg;

    logic          mem_we;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    tx_ctrl_t      tx_ctrl;
    tx_stat_t      tx_stat;

    logic          out_free;
    logic          accept;
    logic          res_load;
    logic [1:0]    res_kind;
    logic [1:0]    res_status;
    logic [31:0]   res_rdata;
    logic          send;
    logic          fail;
    logic [1:0]    fail_status;
    logic [3:0]    try_inc;
    logic [AW-1:0] cnt_new;
    logic [7:0]    len_eff;
    logic          complete;

    svbm_rxbuf #(
        .DEPTH (RX_BUFFER_DEPTH),
        .AW    (AW)
    ) u_rxbuf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (rx_count_reg),
        .wdata (in_data.rx_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    svbm_frame_tx u_frame_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .held  (held_reg),
        .ctrl  (tx_ctrl),
        .stat  (tx_stat)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (fsm_reg == S_READY) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        fsm_next       = fsm_reg;
        phase_next     = phase_reg;
        held_next      = held_reg;
        rx_count_next  = rx_count_reg;
        len_next       = len_reg;
        rsum_next      = rsum_reg;
        elapsed_next   = elapsed_reg;
        try_next       = try_reg;
        rd_idx_next    = rd_idx_reg;
        rdata_next     = rdata_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        mem_we         = 1'b0;
        mem_raddr      = AW'(DATA_IDX) + AW'(rd_idx_reg);
        tx_ctrl        = '0;
        res_load       = 1'b0;
        res_kind       = KIND_DONE;
        res_status     = ST_OK;
        res_rdata      = '0;
        send           = 1'b0;
        fail           = 1'b0;
        fail_status    = ST_TIMEOUT;
        try_inc        = try_reg + 4'd1;
        cnt_new        = (rx_count_reg < CNT_MAX) ? rx_count_reg + AW'(1) : rx_count_reg;
        len_eff        = (rx_count_reg == AW'(LEN_IDX)) ? in_data.rx_byte : len_reg;
        complete       = (cnt_new > AW'(LEN_IDX)) && (len_eff == 8'(cnt_new - AW'(4)));

        unique case (fsm_reg)
            S_READY:
            begin
                if (accept)
                begin
                    unique case (in_data.cmd)
                        CMD_ISSUE:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                res_load = 1'b1;
                                res_kind = KIND_BUSY;
                            end
                            else
                            begin
                                try_next = '0;
                                if ((in_data.instruction == INSTR_READ
                                        && in_data.servo_id != BROADCAST_ID)
                                    || in_data.instruction == INSTR_WRITE)
                                begin
                                    held_next.id       = in_data.servo_id;
                                    held_next.instr    = in_data.instruction;
                                    held_next.reg_addr = in_data.reg_addr;
                                    held_next.count    = (in_data.data_count > MAX_COUNT)
                                                         ? MAX_COUNT : in_data.data_count;
                                    held_next.data     = in_data.write_data;
                                    send               = 1'b1;
                                end
                                else
                                begin
                                    res_load   = 1'b1;
                                    res_status = ST_UNSUPPORTED;
                                end
                            end
                        end
                        CMD_RX:
                        begin
                            if (phase_reg == PH_WAIT)
                            begin
                                mem_we        = 1'b1;
                                rx_count_next = cnt_new;
                                elapsed_next  = '0;
                                len_next      = len_eff;
                                // running sum of bytes from the id onward
                                if (rx_count_reg >= AW'(2))
                                begin
                                    rsum_next = rsum_reg + in_data.rx_byte;
                                end
                                if (complete)
                                begin
                                    if (~rsum_reg != in_data.rx_byte)
                                    begin
                                        fail        = 1'b1;
                                        fail_status = ST_CHECKSUM;
                                    end
                                    else if (held_reg.instr == INSTR_READ
                                             && held_reg.count != 3'd0)
                                    begin
                                        fsm_next    = S_RD_ADDR;
                                        rd_idx_next = '0;
                                        rdata_next  = '0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                        res_load   = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (phase_reg == PH_BCAST)
                            begin
                                phase_next = PH_IDLE;
                                res_load   = 1'b1;
                            end
                            else if (phase_reg == PH_WAIT)
                            begin
                                if (elapsed_reg >= timeout_reg)
                                begin
                                    fail        = 1'b1;
                                    fail_status = ST_TIMEOUT;
                                end
                                else if (elapsed_reg != 8'hFF)
                                begin
                                    elapsed_next = elapsed_reg + 8'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    tx_ctrl.adv            = 1'b1;
                    out_valid_next         = 1'b1;
                    out_word_next          = '0;
                    out_word_next.kind     = KIND_TX;
                    out_word_next.tx_byte  = tx_stat.tx_byte;
                    out_word_next.last     = tx_stat.last;
                    if (tx_stat.last)
                    begin
                        fsm_next = S_READY;
                    end
                end
            end
            S_RD_ADDR:
            begin
                fsm_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                rdata_next = rdata_reg | (32'(mem_rdata) << {rd_idx_reg, 3'b000});
                if (3'(rd_idx_reg) + 3'd1 == held_reg.count)
                begin
                    fsm_next = S_DONE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 2'd1;
                    fsm_next    = S_RD_ADDR;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    phase_next = PH_IDLE;
                    res_load   = 1'b1;
                    res_rdata  = rdata_reg;
                    fsm_next   = S_READY;
                end
            end
            default:
            begin
                fsm_next = S_READY;
            end
        endcase

        // failed attempt: resend while tries remain, else give up
        if (fail)
        begin
            try_next = try_inc;
            if (try_inc < max_tries_reg)
            begin
                send = 1'b1;
            end
            else
            begin
                phase_next = PH_IDLE;
                res_load   = 1'b1;
                res_status = fail_status;
            end
        end

        if (send)
        begin
            tx_ctrl.start = 1'b1;
            fsm_next      = S_SEND;
            rx_count_next = '0;
            elapsed_next  = '0;
            rsum_next     = '0;
            phase_next    = (held_next.id == BROADCAST_ID) ? PH_BCAST : PH_WAIT;
        end

        if (res_load)
        begin
            out_valid_next          = 1'b1;
            out_word_next           = '0;
            out_word_next.kind      = res_kind;
            out_word_next.status    = res_status;
            out_word_next.read_data = res_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_READY;
            phase_reg     <= PH_IDLE;
            held_reg      <= '0;
            rx_count_reg  <= '0;
            len_reg       <= '0;
            rsum_reg      <= '0;
            elapsed_reg   <= '0;
            try_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RST;
            max_tries_reg <= MAX_TRIES_RST;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            rx_count_reg  <= rx_count_next;
            len_reg       <= len_next;
            rsum_reg      <= rsum_next;
            elapsed_reg   <= elapsed_next;
            try_reg       <= try_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                    CFG_MAX_TRIES: max_tries_reg <= cfg_data[3:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        rdata_reg    <= rdata_next;
    end

    a_send_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == S_SEND |-> phase_reg != PH_IDLE)
        else $error("frame in progress with no command held");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_word_reg))
        else $error("stalled output word overwritten");

    a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= CNT_MAX)
        else $error("reply byte count beyond buffer");

    a_fetch_is_read: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == S_RD_ADDR |-> held_reg.instr == INSTR_READ && held_reg.count != 3'd0)
        else $error("data fetch for a command that reads nothing");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.kind != KIND_TX |-> !out_word_reg.last
            && out_word_reg.tx_byte == 8'd0)
        else $error("result word carries frame byte fields");

endmodule
`default_nettype wire

>>> design/svbm_rxbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svbm_rxbuf
// Reply byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svbm_rxbuf #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output      logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> design/svbm_frame_tx.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svbm_frame_tx
// Frame builder: walks FF FF id len instr reg payload ~sum one byte per word.
// ----------------------------------------------------------------------------
module svbm_frame_tx
    import svbm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire held_cmd_t held,
    input  wire tx_ctrl_t  ctrl,
    output      tx_stat_t  stat
);

    logic [3:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic       is_write;
    logic [7:0] len;
    logic [3:0] last_idx;
    logic [1:0] data_sel;
    logic [7:0] byte_val;

    always_comb
    begin
        is_write = (held.instr == INSTR_WRITE);
        len      = is_write ? 8'(held.count) + 8'd3 : 8'd4;
        last_idx = is_write ? 4'(held.count) + 4'd6 : 4'd7;
        data_sel = 2'(idx_reg - 4'd6);

        priority if (idx_reg < 4'd2)
        begin
            byte_val = SYNC_BYTE;
        end
        else if (idx_reg == last_idx)
        begin
            byte_val = ~sum_reg;
        end
        else
        begin
            unique case (idx_reg)
                4'd2:    byte_val = held.id;
                4'd3:    byte_val = len;
                4'd4:    byte_val = held.instr;
                4'd5:    byte_val = held.reg_addr;
                default: byte_val = is_write ? held.data[{data_sel, 3'b000} +: 8]
                                             : 8'(held.count);
            endcase
        end

        stat.tx_byte = byte_val;
        stat.last    = (idx_reg == last_idx);

        idx_next = idx_reg;
        sum_next = sum_reg;
        priority if (ctrl.start)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        else if (ctrl.adv)
        begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg >= 4'd2)
            begin
                sum_next = sum_reg + byte_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

endmodule
`default_nettype wire
